### hdl/decimal_modular_exponentiation_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef DECIMAL_MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define DECIMAL_MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// Same-cycle implication under the asynchronous reset.
`define DME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dme assertion failed");

// Next-cycle implication under the asynchronous reset.
`define DME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dme assertion failed");

`endif

### hdl/dme_pkg.sv
package dme_pkg;
	localparam int MOD_BITS_DEF = 60;
	localparam int CFG_W = 60;
	localparam int RES_W = 60;
	localparam int DIG_W = 4;
	localparam logic [63:0] MOD_RESET = 64'd1000000007;
	localparam logic CMD_BASE = 1'b0;
	localparam logic CMD_EXP = 1'b1;
endpackage

### hdl/dme_if.sv
interface dme_in_if
	import dme_pkg::*;
();
	logic valid;
	logic ready;
	logic command;
	logic [DIG_W-1:0] digit;
	logic last;

	modport source (output valid, output command, output digit, output last, input ready);
	modport sink (input valid, input command, input digit, input last, output ready);
endinterface

interface dme_out_if
	import dme_pkg::*;
();
	logic valid;
	logic ready;
	logic [RES_W-1:0] power_residue;

	modport source (output valid, output power_residue, input ready);
	modport sink (input valid, input power_residue, output ready);
endinterface

### hdl/dme_mulmod.sv
// Serial modular multiplier: result = a * y mod m, y taken MSB first,
// one double-and-add step per cycle. a must already be below m.
module dme_mulmod
	import dme_pkg::*;
#(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [MOD_BITS-1:0]   m,
	input  logic [MOD_BITS-1:0]   a,
	input  logic [MOD_BITS+3:0]   y,
	output logic                  done,
	output logic [MOD_BITS-1:0]   result
);
	localparam int YB = MOD_BITS + 4;
	localparam int CW = $clog2(YB + 1);
	localparam int TW = MOD_BITS + 2;

	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] a_q;
	logic [YB-1:0]       y_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [TW-1:0] t;
	logic [TW-1:0] m1;
	logic [TW-1:0] m2;
	logic [TW-1:0] t_next;

	// 2*acc + bit*a stays below 3m; subtract m or 2m as needed
	always_comb begin
		t  = {1'b0, acc_q, 1'b0} + (y_q[YB-1] ? {2'b00, a_q} : {TW{1'b0}});
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		if (t >= m2) begin
			t_next = t - m2;
		end else if (t >= m1) begin
			t_next = t - m1;
		end else begin
			t_next = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			a_q    <= '0;
			y_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				acc_q  <= '0;
				a_q    <= a;
				y_q    <= y;
				cnt_q  <= CW'(YB);
			end else if (busy_q) begin
				acc_q <= t_next[MOD_BITS-1:0];
				y_q   <= {y_q[YB-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign result = acc_q;
endmodule

### hdl/decimal_modular_exponentiation_unit.sv
// Decimal modular exponentiation: computes base^exponent mod modulus, where base and
// exponent arrive one decimal digit per input beat, most significant digit first
// (command 0 = base digit, command 1 = exponent digit, last set on the final exponent
// digit), and the modulus sits in a configuration register (reset 1000000007, a zero
// modulus acts as one). Only the final exponent digit produces an output beat; the
// block then returns to base 0, running power 1. All arithmetic runs through a single
// serial double-and-add modular multiplier that retires one multiplier bit per cycle.
// A base digit takes two products (reduce base, fold in the digit). An exponent digit
// takes fifteen products (reduce the running power, raise it to the tenth, reduce the
// base, four square/multiply pairs over the digit bits, final product). The input is
// not ready while a digit is being worked on; a finished result waits in the output
// register while the next digit is accepted.
// Write the modulus only while the block is idle.
module decimal_modular_exponentiation_unit
	import dme_pkg::*;
#(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	dme_in_if.sink           in_ch,
	dme_out_if.source        out_ch
);
	localparam int YB = MOD_BITS + 4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BRED,
		S_FOLD,
		S_RRED,
		S_SQ1,
		S_SQ2,
		S_MUL5,
		S_SQ3,
		S_DSQ,
		S_DMUL,
		S_FIN,
		S_OUT
	} state_t;

	state_t state_q;

	logic [MOD_BITS-1:0] mod_q;
	logic [MOD_BITS-1:0] base_q;   // base residue, may exceed a changed modulus
	logic [MOD_BITS-1:0] pow_q;    // running power
	logic [MOD_BITS-1:0] b_q;      // base reduced
	logic [MOD_BITS-1:0] p_q;      // running power reduced, later its tenth power
	logic [MOD_BITS-1:0] t_q;      // scratch for the power chain and the result
	logic [MOD_BITS-1:0] q_q;      // base raised to the digit, built bit by bit
	logic [1:0]          k_q;      // digit bit under work
	logic                cmd_q;
	logic [DIG_W-1:0]    digit_q;
	logic                last_q;
	logic                start_q;
	logic                out_valid_q;
	logic [RES_W-1:0]    out_data_q;

	logic [MOD_BITS-1:0] m_eff;
	logic [MOD_BITS-1:0] one_r;
	logic [MOD_BITS-1:0] op_a;
	logic [YB-1:0]       op_y;
	logic [YB-1:0]       fold_y;
	logic [YB-1:0]       y_one;
	logic                mm_done;
	logic [MOD_BITS-1:0] mm_res;
	logic [63:0]         cfg_wide;
	logic [63:0]         res_wide;
	logic                out_free;

	// Zero modulus behaves as one; 1 mod m is then zero
	always_comb begin
		m_eff = (mod_q == '0) ? MOD_BITS'(1) : mod_q;
		one_r = (m_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
		y_one = YB'(1);
		// base*10 + digit as 8b + 2b + d, fits in four extra bits
		fold_y = {1'b0, b_q, 3'b000} + {3'b000, b_q, 1'b0} + {{(YB-DIG_W){1'b0}}, digit_q};
	end

	// Operand select for the shared multiplier; the first operand is always reduced
	always_comb begin
		case (state_q)
			S_BRED: begin
				op_a = one_r;
				op_y = {4'b0000, base_q};
			end
			S_FOLD: begin
				op_a = one_r;
				op_y = fold_y;
			end
			S_RRED: begin
				op_a = one_r;
				op_y = {4'b0000, pow_q};
			end
			S_SQ1: begin
				op_a = p_q;
				op_y = {4'b0000, p_q};
			end
			S_SQ2, S_SQ3: begin
				op_a = t_q;
				op_y = {4'b0000, t_q};
			end
			S_MUL5: begin
				op_a = t_q;
				op_y = {4'b0000, p_q};
			end
			S_DSQ: begin
				op_a = q_q;
				op_y = {4'b0000, q_q};
			end
			S_DMUL: begin
				op_a = q_q;
				op_y = digit_q[k_q] ? {4'b0000, b_q} : y_one;
			end
			S_FIN: begin
				op_a = p_q;
				op_y = {4'b0000, q_q};
			end
			default: begin
				op_a = '0;
				op_y = '0;
			end
		endcase
	end

	dme_mulmod #(
		.MOD_BITS(MOD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.m      (m_eff),
		.a      (op_a),
		.y      (op_y),
		.done   (mm_done),
		.result (mm_res)
	);

	// Keep only the low MOD_BITS bits of a written modulus
	assign cfg_wide = {{(64-CFG_W){1'b0}}, cfg_wdata};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET[MOD_BITS-1:0];
		end else if (cfg_we) begin
			mod_q <= cfg_wide[MOD_BITS-1:0];
		end
	end

	assign res_wide = {{(64-MOD_BITS){1'b0}}, t_q};
	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			pow_q       <= MOD_BITS'(1);
			b_q         <= '0;
			p_q         <= '0;
			t_q         <= '0;
			q_q         <= '0;
			k_q         <= '0;
			cmd_q       <= CMD_BASE;
			digit_q     <= '0;
			last_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			start_q <= 1'b0;
			// drop the result beat once taken
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						cmd_q   <= in_ch.command;
						digit_q <= in_ch.digit;
						last_q  <= in_ch.last;
						start_q <= 1'b1;
						state_q <= S_BRED;
					end
				end
				S_BRED: begin
					if (mm_done) begin
						b_q     <= mm_res;
						start_q <= 1'b1;
						state_q <= (cmd_q == CMD_EXP) ? S_RRED : S_FOLD;
					end
				end
				S_FOLD: begin
					if (mm_done) begin
						base_q  <= mm_res;
						state_q <= S_IDLE;
					end
				end
				S_RRED: begin
					if (mm_done) begin
						p_q     <= mm_res;
						start_q <= 1'b1;
						state_q <= S_SQ1;
					end
				end
				S_SQ1: begin
					if (mm_done) begin
						t_q     <= mm_res;
						start_q <= 1'b1;
						state_q <= S_SQ2;
					end
				end
				S_SQ2: begin
					if (mm_done) begin
						t_q     <= mm_res;
						start_q <= 1'b1;
						state_q <= S_MUL5;
					end
				end
				S_MUL5: begin
					if (mm_done) begin
						t_q     <= mm_res;
						start_q <= 1'b1;
						state_q <= S_SQ3;
					end
				end
				S_SQ3: begin
					if (mm_done) begin
						p_q     <= mm_res;
						q_q     <= one_r;
						k_q     <= 2'd3;
						start_q <= 1'b1;
						state_q <= S_DSQ;
					end
				end
				S_DSQ: begin
					if (mm_done) begin
						q_q     <= mm_res;
						start_q <= 1'b1;
						state_q <= S_DMUL;
					end
				end
				S_DMUL: begin
					if (mm_done) begin
						q_q     <= mm_res;
						start_q <= 1'b1;
						if (k_q == 2'd0) begin
							state_q <= S_FIN;
						end else begin
							k_q     <= k_q - 2'd1;
							state_q <= S_DSQ;
						end
					end
				end
				S_FIN: begin
					if (mm_done) begin
						if (last_q) begin
							t_q     <= mm_res;
							state_q <= S_OUT;
						end else begin
							pow_q   <= mm_res;
							state_q <= S_IDLE;
						end
					end
				end
				S_OUT: begin
					// hold until the output register is free, then restart
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_wide[RES_W-1:0];
						base_q      <= '0;
						pow_q       <= MOD_BITS'(1);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.power_residue = out_data_q;
endmodule

### hdl/dme_checker.sv
`include "decimal_modular_exponentiation_unit_defines.svh"

module dme_checker
	import dme_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [RES_W-1:0] out_data
);
	// a stalled result beat holds
	`DME_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`DME_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data))
	// one digit at a time: busy right after an accepted beat
	`DME_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// no result can appear the cycle after a digit is taken
	`DME_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid))
endmodule

bind decimal_modular_exponentiation_unit dme_checker u_dme_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.power_residue)
);
